### rtl/core/dbq_pkg.sv
// Shared operation codes and control types for the bounded deque block.
package dbq_pkg;

  // Operation codes carried on the operation port.
  localparam logic [2:0] OP_APPEND_BACK = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT  = 3'd1;
  localparam logic [2:0] OP_DROP_BACK   = 3'd2;
  localparam logic [2:0] OP_DROP_FRONT  = 3'd3;
  localparam logic [2:0] OP_SEARCH      = 3'd4;

  // Width of a stored value.
  localparam int unsigned DATA_W = 32;

  // Search launch from the controller to the store.
  typedef struct packed {
    logic              launch;
    logic [DATA_W-1:0] key;
  } search_req_t;

  // Search completion from the store back to the controller.
  typedef struct packed {
    logic finished;
    logic found;
  } search_rsp_t;

endpackage

### rtl/core/bounded_deque_with_search_unit.sv
// Insert and removal results are registered at the accepting edge.
// Throughput: inserts and removals are taken every cycle unless a search holds busy;
// busy stays low for them. A search of a non-empty deque holds busy while the walker reads
// entries from the front, until a hit or until every live entry misses; its result beat
// is registered as busy drops. Empty-deque searches skip the walker; results cannot be stalled.
// Reset clears the front pointer and entry count; memory contents stay as they were.
module bounded_deque_with_search_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          operation,
  input  logic signed [dbq_pkg::DATA_W-1:0]   value,
  output logic                                done,
  output logic                                success,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [IDX_W-1:0]     front;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     front_next;
  logic [CNT_W-1:0]     count_next;
  logic                 ok_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [IDX_W:0]       back_sum;
  logic [IDX_W-1:0]     back_pos;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  dbq_pkg::search_req_t req;
  dbq_pkg::search_rsp_t rsp;

  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  // Ring position just past the back entry.
  assign back_sum = {1'b0, front} + (IDX_W + 1)'(count);
  assign back_pos = (back_sum >= (IDX_W + 1)'(CAPACITY)) ?
                    IDX_W'(back_sum - (IDX_W + 1)'(CAPACITY)) : IDX_W'(back_sum);

  // Decode the command into pointer updates and a memory write.
  always_comb begin
    front_next = front;
    count_next = count;
    ok_next    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = back_pos;
    unique case (operation)
      dbq_pkg::OP_APPEND_BACK: begin
        if (!full) begin
          wr_en      = accept;
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      dbq_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          front_next = (front == '0) ? IDX_W'(CAPACITY - 1) : front - IDX_W'(1);
          wr_en      = accept;
          wr_addr    = front_next;
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      dbq_pkg::OP_DROP_BACK: begin
        if (!empty) begin
          count_next = count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      dbq_pkg::OP_DROP_FRONT: begin
        if (!empty) begin
          front_next = (front == IDX_W'(CAPACITY - 1)) ? '0 : front + IDX_W'(1);
          count_next = count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // A search of a non-empty deque goes to the store walker.
  assign req.launch = accept && (operation == dbq_pkg::OP_SEARCH) && !empty;
  assign req.key    = value;

  dbq_store #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (value),
    .req       (req),
    .req_front (front),
    .req_count (count),
    .rsp       (rsp)
  );

  // Pointer state and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
      if (req.launch) begin
        busy <= 1'b1;
      end else if (rsp.finished) begin
        busy <= 1'b0;
      end
    end
  end

  // Result beat: registered from an accepted immediate command, or when the walker finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && !req.launch) || rsp.finished;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.finished) begin
      success     <= rsp.found;
      entry_count <= count;
    end else begin
      success     <= ok_next;
      entry_count <= count_next;
    end
  end

endmodule

### rtl/core/dbq_store.sv
// Ring store memory with its write port and the sequential search walker.
module dbq_store #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [dbq_pkg::DATA_W-1:0]  wr_data,
  input  dbq_pkg::search_req_t        req,
  input  logic [IDX_W-1:0]            req_front,
  input  logic [CNT_W-1:0]            req_count,
  output dbq_pkg::search_rsp_t        rsp
);

  // Entry storage: one write port, one registered read port.
  logic [dbq_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [dbq_pkg::DATA_W-1:0] rd_data;

  // Walker state.
  logic                       active;
  logic [IDX_W-1:0]           rd_addr;
  logic [CNT_W-1:0]           left;
  logic                       rd_vld;
  logic [dbq_pkg::DATA_W-1:0] key;
  logic                       issue;
  logic                       hit;
  logic                       miss;

  assign issue = active && (left != '0);
  assign hit   = active && rd_vld && (rd_data == key);
  assign miss  = active && !rd_vld && (left == '0);

  // Memory write and read, both clocked.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Walk the live entries from the front, one read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_vld <= 1'b0;
      left   <= '0;
      rd_addr <= '0;
    end else if (req.launch) begin
      active  <= 1'b1;
      rd_vld  <= 1'b0;
      left    <= req_count;
      rd_addr <= req_front;
      key     <= req.key;
    end else if (hit || miss) begin
      active <= 1'b0;
      rd_vld <= 1'b0;
    end else if (active) begin
      rd_vld <= issue;
      if (issue) begin
        left    <= left - CNT_W'(1);
        rd_addr <= (rd_addr == IDX_W'(CAPACITY - 1)) ? '0 : rd_addr + IDX_W'(1);
      end
    end
  end

  // Completion beat back to the controller.
  assign rsp.finished = hit || miss;
  assign rsp.found    = hit;

endmodule

### test/deque_checker.sv
// Checker for the bounded deque: mirrors the deque and compares every result beat.
`timescale 1ns / 1ps
module deque_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [2:0]                        operation,
  input  logic signed [dbq_pkg::DATA_W-1:0] value,
  input  logic                              done,
  input  logic                              success,
  input  logic [$clog2(CAPACITY+1)-1:0]     entry_count,
  output int                                fail_count,
  output int                                pending
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // One predicted result, with the command that caused it for reporting.
  typedef struct packed {
    logic [2:0]                 op;
    logic [dbq_pkg::DATA_W-1:0] key;
    logic                       ok;
    logic [CNT_W-1:0]           count;
  } answer_t;

  // Mirror of the deque: ring of slots, front position and live count.
  logic [dbq_pkg::DATA_W-1:0] slots [CAPACITY];
  int unsigned                head;
  int unsigned                fill;
  answer_t                    answers_due [$];

  initial fail_count = 0;

  // Apply one command to the mirror and return the result it should give.
  function automatic answer_t deque_step(input logic [2:0] op,
                                         input logic [dbq_pkg::DATA_W-1:0] key);
    answer_t a;
    a.op  = op;
    a.key = key;
    a.ok  = 1'b0;
    case (op)
      dbq_pkg::OP_APPEND_BACK: begin
        if (fill < CAPACITY) begin
          slots[(head + fill) % CAPACITY] = key;
          fill++;
          a.ok = 1'b1;
        end
      end
      dbq_pkg::OP_PUSH_FRONT: begin
        if (fill < CAPACITY) begin
          head = (head + CAPACITY - 1) % CAPACITY;
          slots[head] = key;
          fill++;
          a.ok = 1'b1;
        end
      end
      dbq_pkg::OP_DROP_BACK: begin
        if (fill > 0) begin
          fill--;
          a.ok = 1'b1;
        end
      end
      dbq_pkg::OP_DROP_FRONT: begin
        if (fill > 0) begin
          head = (head + 1) % CAPACITY;
          fill--;
          a.ok = 1'b1;
        end
      end
      dbq_pkg::OP_SEARCH: begin
        // Only live entries are compared, from the front to the back.
        for (int k = 0; k < fill; k++) begin
          if (slots[(head + k) % CAPACITY] == key) a.ok = 1'b1;
        end
      end
      default: begin
        // Unknown codes leave the deque untouched and report failure.
      end
    endcase
    a.count = fill[CNT_W-1:0];
    return a;
  endfunction

  // Count a failure; only the first ten are printed in full.
  task automatic note_failure(input string what, input answer_t want);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: op %0d value %h expected success %0b count %0d,",
               $realtime, what, want.op, want.key, want.ok, want.count,
               " got success %0b count %0d", success, entry_count);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      head = 0;
      fill = 0;
      answers_due.delete();
      pending <= 0;
    end else begin
      // Result beat first: it always belongs to a command taken at an earlier edge.
      if (done) begin
        if (answers_due.size() == 0) begin
          want = '0;
          note_failure("result beat with nothing predicted", want);
        end else begin
          want = answers_due.pop_front();
          if (success !== want.ok || entry_count !== want.count) begin
            note_failure("result mismatch", want);
          end
        end
      end
      // Command beat: predict its result and queue it.
      if (start && !busy) begin
        answers_due.push_back(deque_step(operation, value));
      end
      pending <= answers_due.size();
    end
  end

endmodule

### test/testbench.sv
// Top of the deque testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned CAPACITY = 16;
  localparam int SEGMENTS = 38;
  localparam int SEG_LEN  = 50;

  // Codes outside the defined set; the block must ignore them.
  localparam logic [2:0] OP_RESERVED_5 = 3'd5;
  localparam logic [2:0] OP_RESERVED_6 = 3'd6;
  localparam logic [2:0] OP_RESERVED_7 = 3'd7;

  // Command mixes that steer the deque toward full, empty or heavy searching.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_PROBE} mix_t;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [2:0]                        operation;
  logic signed [dbq_pkg::DATA_W-1:0] value;
  logic                              done;
  logic                              success;
  logic [$clog2(CAPACITY+1)-1:0]     entry_count;
  int                                fail_count;
  int                                pending;

  // A small pool of values so that searches often hit stored entries.
  logic [dbq_pkg::DATA_W-1:0] common_values [8] = '{32'h0000_0000, 32'h0000_0001,
                                                    32'hFFFF_FFFF, 32'h8000_0000,
                                                    32'h7FFF_FFFF, 32'h5555_5555,
                                                    32'hAAAA_AAAA, 32'h0000_002A};

  bounded_deque_with_search_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .done        (done),
    .success     (success),
    .entry_count (entry_count)
  );

  deque_checker #(.CAPACITY(CAPACITY)) deque_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .done        (done),
    .success     (success),
    .entry_count (entry_count),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Present one command and hold it until the block takes the beat.
  task automatic issue(input logic [2:0] op, input logic [dbq_pkg::DATA_W-1:0] v);
    operation <= op;
    value     <= v;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending until every predicted result has come back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly no gap, some short ones, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [dbq_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return common_values[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [2:0] choose_op(input mix_t mix);
    int         r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      case ($urandom_range(0, 2))
        0:       op = OP_RESERVED_5;
        1:       op = OP_RESERVED_6;
        default: op = OP_RESERVED_7;
      endcase
      return op;
    end
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 40) op = dbq_pkg::OP_APPEND_BACK;
        else if (r < 70) op = dbq_pkg::OP_PUSH_FRONT;
        else if (r < 85) op = dbq_pkg::OP_SEARCH;
        else if (r < 93) op = dbq_pkg::OP_DROP_BACK;
        else op = dbq_pkg::OP_DROP_FRONT;
      end
      MIX_DRAIN: begin
        if (r < 10) op = dbq_pkg::OP_APPEND_BACK;
        else if (r < 20) op = dbq_pkg::OP_PUSH_FRONT;
        else if (r < 40) op = dbq_pkg::OP_SEARCH;
        else if (r < 70) op = dbq_pkg::OP_DROP_BACK;
        else op = dbq_pkg::OP_DROP_FRONT;
      end
      MIX_BALANCED: begin
        if (r < 25) op = dbq_pkg::OP_APPEND_BACK;
        else if (r < 45) op = dbq_pkg::OP_PUSH_FRONT;
        else if (r < 65) op = dbq_pkg::OP_SEARCH;
        else if (r < 82) op = dbq_pkg::OP_DROP_BACK;
        else op = dbq_pkg::OP_DROP_FRONT;
      end
      default: begin
        if (r < 15) op = dbq_pkg::OP_APPEND_BACK;
        else if (r < 25) op = dbq_pkg::OP_PUSH_FRONT;
        else if (r < 75) op = dbq_pkg::OP_SEARCH;
        else if (r < 88) op = dbq_pkg::OP_DROP_BACK;
        else op = dbq_pkg::OP_DROP_FRONT;
      end
    endcase
    return op;
  endfunction

  initial begin
    mix_t mix;
    bit   gaps_on;
    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= dbq_pkg::OP_APPEND_BACK;
    value     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty deque corners, unknown codes, extreme values, hits and misses.
    issue(dbq_pkg::OP_SEARCH, 32'h0000_0000);
    issue(dbq_pkg::OP_DROP_BACK, 32'h0000_0000);
    issue(dbq_pkg::OP_DROP_FRONT, 32'hFFFF_FFFF);
    issue(OP_RESERVED_5, $urandom);
    issue(OP_RESERVED_6, $urandom);
    issue(OP_RESERVED_7, $urandom);
    issue(dbq_pkg::OP_APPEND_BACK, 32'h8000_0000);
    issue(dbq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    issue(dbq_pkg::OP_APPEND_BACK, 32'hFFFF_FFFF);
    issue(dbq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    issue(dbq_pkg::OP_SEARCH, 32'h8000_0000);
    issue(dbq_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    issue(dbq_pkg::OP_SEARCH, 32'h1234_5678);
    issue(dbq_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    issue(dbq_pkg::OP_DROP_BACK, 32'h0000_0000);
    issue(dbq_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    issue(dbq_pkg::OP_DROP_FRONT, 32'h0000_0000);
    issue(dbq_pkg::OP_SEARCH, 32'h0000_0000);
    issue(dbq_pkg::OP_APPEND_BACK, 32'hAAAA_AAAA);
    issue(dbq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
    settle();

    // Random: segments with a fixed mix so the deque swings between full and empty.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mix     = mix_t'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < SEG_LEN; n++) begin
        issue(choose_op(mix), pick_value());
        if (gaps_on) idle(gap_len());
      end
      if ($urandom_range(0, 3) == 0) settle();
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dbq_pkg.sv
rtl/core/dbq_store.sv
rtl/core/bounded_deque_with_search_unit.sv
test/deque_checker.sv
test/testbench.sv
